[src/cifs_pkg.sv]
// ---------------------------------------------------------------------------
// cifs_pkg: shared types and constants of the cell image fragment scaler
// Register indexes, geometry record, queue entry and clamp helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package cifs_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_CELL_WIDTH     = 3'd2;
	localparam logic [2:0] REG_CELL_HEIGHT    = 3'd3;
	localparam logic [2:0] REG_SPAN_COLUMNS   = 3'd4;
	localparam logic [2:0] REG_SPAN_LINES     = 3'd5;
	localparam logic [2:0] REG_PLACEMENT_MODE = 3'd6;
	localparam logic [2:0] REG_DEFAULT_COLOR  = 3'd7;

	// resize codes
	localparam logic [1:0] RSZ_NONE    = 2'd0;
	localparam logic [1:0] RSZ_FIT     = 2'd1;
	localparam logic [1:0] RSZ_FILL    = 2'd2;
	localparam logic [1:0] RSZ_STRETCH = 2'd3;

	// alignment along one axis
	localparam logic [1:0] AL_START  = 2'd0;
	localparam logic [1:0] AL_CENTER = 2'd1;
	localparam logic [1:0] AL_END    = 2'd2;

	// source index bits: quotient bits of the per-pixel division
	localparam int SRC_BITS  = 12;
	// quotient bits of the placed-size division
	localparam int DIV_STEPS = 29;
	// queue depth between front and back
	localparam int QDEPTH    = 4;

	typedef enum logic [4:0] {
		G_SIZE = 5'b00001,
		G_CMP  = 5'b00010,
		G_DIV  = 5'b00100,
		G_OFS  = 5'b01000,
		G_DONE = 5'b10000
	} gstate_t;

	typedef struct packed {
		logic [12:0]        iw;
		logic [12:0]        ih;
		logic [8:0]         cw;
		logic [8:0]         ch;
		logic [28:0]        pw;
		logic [28:0]        ph;
		logic signed [29:0] xo;
		logic signed [29:0] yo;
		logic [31:0]        dcol;
	} geom_t;

	typedef struct packed {
		logic        ld;
		logic [11:0] ld_idx;
		logic [31:0] ld_rgba;
		logic        cov;
		logic [28:0] dx;
		logic [28:0] dy;
	} q_item_t;

	function automatic logic [12:0] clamp13(input logic [12:0] v);
		logic [12:0] r;
		if (v == 13'd0) r = 13'd1;
		else if (v > 13'd4096) r = 13'd4096;
		else r = v;
		return r;
	endfunction

	function automatic logic [8:0] clamp9(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) r = 9'd1;
		else if (v > 9'd256) r = 9'd256;
		else r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

[src/cifs_geom.sv]
// ---------------------------------------------------------------------------
// cifs_geom: configuration registers and placement geometry
// Holds the registers and works out placed size and offsets after each write.
// ---------------------------------------------------------------------------
`default_nettype none

module cifs_geom (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output cifs_pkg::geom_t   geom,
	output logic              ready
);

	logic [12:0] iw_raw_q, ih_raw_q;
	logic [8:0]  cw_raw_q, ch_raw_q, sc_raw_q, sl_raw_q;
	logic [5:0]  mode_q;
	logic [31:0] dcol_q;

	cifs_pkg::gstate_t state_q;

	logic [12:0]        iw_q, ih_q;
	logic [8:0]         cw_q, ch_q;
	logic [16:0]        gw_q, gh_q;
	logic [1:0]         rsz_q, ha_q, va_q;
	logic [28:0]        pw_q, ph_q;
	logic signed [29:0] xo_q, yo_q;
	logic [28:0]        dnum_q, dquo_q;
	logic [12:0]        dden_q, drem_q;
	logic               dsel_q;
	logic [4:0]         cnt_q;

	logic [3:0]         align;
	logic [1:0]         ha_c, va_c;
	logic [28:0]        pa, pb;
	logic               wb;
	logic [13:0]        dt;
	logic               dge;
	logic signed [29:0] sx, sy, hx, hy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_raw_q <= 13'd1;
			ih_raw_q <= 13'd1;
			cw_raw_q <= 9'd8;
			ch_raw_q <= 9'd16;
			sc_raw_q <= 9'd1;
			sl_raw_q <= 9'd1;
			mode_q   <= 6'd0;
			dcol_q   <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				cifs_pkg::REG_IMAGE_WIDTH:    iw_raw_q <= cfg_data[12:0];
				cifs_pkg::REG_IMAGE_HEIGHT:   ih_raw_q <= cfg_data[12:0];
				cifs_pkg::REG_CELL_WIDTH:     cw_raw_q <= cfg_data[8:0];
				cifs_pkg::REG_CELL_HEIGHT:    ch_raw_q <= cfg_data[8:0];
				cifs_pkg::REG_SPAN_COLUMNS:   sc_raw_q <= cfg_data[8:0];
				cifs_pkg::REG_SPAN_LINES:     sl_raw_q <= cfg_data[8:0];
				cifs_pkg::REG_PLACEMENT_MODE: mode_q   <= cfg_data[5:0];
				cifs_pkg::REG_DEFAULT_COLOR:  dcol_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// split alignment into horizontal and vertical parts
	always_comb begin
		align = mode_q[5:2];
		if (align inside {4'd0, 4'd3, 4'd6}) ha_c = cifs_pkg::AL_START;
		else if (align inside {4'd1, 4'd4, 4'd7}) ha_c = cifs_pkg::AL_CENTER;
		else if (align inside {4'd2, 4'd5, 4'd8}) ha_c = cifs_pkg::AL_END;
		else ha_c = cifs_pkg::AL_START;
		if (align inside {[4'd3:4'd5]}) va_c = cifs_pkg::AL_CENTER;
		else if (align inside {[4'd6:4'd8]}) va_c = cifs_pkg::AL_END;
		else va_c = cifs_pkg::AL_START;
	end

	always_comb begin
		pa  = 29'(gw_q * ih_q);
		pb  = 29'(gh_q * iw_q);
		wb  = (rsz_q == cifs_pkg::RSZ_FIT) ? (pa <= pb) : (pa >= pb);
		dt  = {drem_q, dnum_q[28]};
		dge = dt >= {1'b0, dden_q};
		sx  = $signed({13'd0, gw_q}) - $signed({1'b0, pw_q});
		sy  = $signed({13'd0, gh_q}) - $signed({1'b0, ph_q});
		hx  = $signed(sx + {29'd0, sx[29]}) >>> 1;
		hy  = $signed(sy + {29'd0, sy[29]}) >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cifs_pkg::G_SIZE;
		end else if (cfg_we) begin
			state_q <= cifs_pkg::G_SIZE;
		end else begin
			case (state_q)
				cifs_pkg::G_SIZE: state_q <= cifs_pkg::G_CMP;
				cifs_pkg::G_CMP: begin
					if (rsz_q == cifs_pkg::RSZ_FIT || rsz_q == cifs_pkg::RSZ_FILL)
						state_q <= cifs_pkg::G_DIV;
					else
						state_q <= cifs_pkg::G_OFS;
				end
				cifs_pkg::G_DIV: begin
					if (cnt_q == 5'(cifs_pkg::DIV_STEPS - 1)) state_q <= cifs_pkg::G_OFS;
				end
				cifs_pkg::G_OFS:  state_q <= cifs_pkg::G_DONE;
				cifs_pkg::G_DONE: state_q <= cifs_pkg::G_DONE;
				default:          state_q <= cifs_pkg::G_SIZE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cifs_pkg::G_SIZE: begin
				iw_q  <= cifs_pkg::clamp13(iw_raw_q);
				ih_q  <= cifs_pkg::clamp13(ih_raw_q);
				cw_q  <= cifs_pkg::clamp9(cw_raw_q);
				ch_q  <= cifs_pkg::clamp9(ch_raw_q);
				gw_q  <= 17'(cifs_pkg::clamp9(sc_raw_q) * cifs_pkg::clamp9(cw_raw_q));
				gh_q  <= 17'(cifs_pkg::clamp9(sl_raw_q) * cifs_pkg::clamp9(ch_raw_q));
				rsz_q <= mode_q[1:0];
				ha_q  <= ha_c;
				va_q  <= va_c;
			end
			cifs_pkg::G_CMP: begin
				drem_q <= 13'd0;
				dquo_q <= 29'd0;
				cnt_q  <= 5'd0;
				case (rsz_q)
					cifs_pkg::RSZ_FIT, cifs_pkg::RSZ_FILL: begin
						if (wb) begin
							pw_q   <= {12'd0, gw_q};
							dnum_q <= pa;
							dden_q <= iw_q;
							dsel_q <= 1'b1;
						end else begin
							ph_q   <= {12'd0, gh_q};
							dnum_q <= pb;
							dden_q <= ih_q;
							dsel_q <= 1'b0;
						end
					end
					cifs_pkg::RSZ_STRETCH: begin
						pw_q <= {12'd0, gw_q};
						ph_q <= {12'd0, gh_q};
					end
					default: begin
						pw_q <= {16'd0, iw_q};
						ph_q <= {16'd0, ih_q};
					end
				endcase
			end
			cifs_pkg::G_DIV: begin
				// restoring division, one quotient bit a cycle
				drem_q <= dge ? 13'(dt - {1'b0, dden_q}) : dt[12:0];
				dnum_q <= {dnum_q[27:0], 1'b0};
				dquo_q <= {dquo_q[27:0], dge};
				cnt_q  <= cnt_q + 5'd1;
				if (cnt_q == 5'(cifs_pkg::DIV_STEPS - 1)) begin
					if (dsel_q) ph_q <= {dquo_q[27:0], dge};
					else pw_q <= {dquo_q[27:0], dge};
				end
			end
			cifs_pkg::G_OFS: begin
				case (ha_q)
					cifs_pkg::AL_CENTER: xo_q <= hx;
					cifs_pkg::AL_END:    xo_q <= sx;
					default:             xo_q <= 30'sd0;
				endcase
				case (va_q)
					cifs_pkg::AL_CENTER: yo_q <= hy;
					cifs_pkg::AL_END:    yo_q <= sy;
					default:             yo_q <= 30'sd0;
				endcase
			end
			default: ;
		endcase
	end

	assign ready     = (state_q == cifs_pkg::G_DONE);
	assign geom.iw   = iw_q;
	assign geom.ih   = ih_q;
	assign geom.cw   = cw_q;
	assign geom.ch   = ch_q;
	assign geom.pw   = pw_q;
	assign geom.ph   = ph_q;
	assign geom.xo   = xo_q;
	assign geom.yo   = yo_q;
	assign geom.dcol = dcol_q;

endmodule

`default_nettype wire

[src/cifs_front.sv]
// ---------------------------------------------------------------------------
// cifs_front: input stage
// Accepts beats, sorts loads from renders, places render pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module cifs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [79:0]         s_tdata,
	input  logic                s_tuser,
	input  cifs_pkg::geom_t     geom,
	input  logic                geom_ready,
	input  logic                full,
	output logic                push,
	output cifs_pkg::q_item_t   item
);

	logic        v_s1, ld_s1;
	logic [11:0] idx_s1;
	logic [31:0] rgba_s1;
	logic [7:0]  col_s1, line_s1, px_s1, py_s1;

	logic [15:0]        gx, gy;
	logic signed [30:0] dx, dy;
	logic               take;

	assign s_tready = geom_ready && (!v_s1 || !full);
	assign take     = s_tvalid && s_tready;
	assign push     = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (take) v_s1 <= 1'b1;
		else if (push) v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ld_s1   <= !s_tuser;
			idx_s1  <= s_tdata[11:0];
			rgba_s1 <= s_tdata[43:12];
			col_s1  <= s_tdata[51:44];
			line_s1 <= s_tdata[59:52];
			px_s1   <= s_tdata[67:60];
			py_s1   <= s_tdata[75:68];
		end
	end

	always_comb begin
		gx = 16'(col_s1 * geom.cw + {9'd0, px_s1});
		gy = 16'(line_s1 * geom.ch + {9'd0, py_s1});
		dx = $signed({15'd0, gx}) - $signed({geom.xo[29], geom.xo});
		dy = $signed({15'd0, gy}) - $signed({geom.yo[29], geom.yo});
		item.ld      = ld_s1;
		item.ld_idx  = idx_s1;
		item.ld_rgba = rgba_s1;
		item.cov     = !dx[30] && (dx < $signed({2'b0, geom.pw}))
		            && !dy[30] && (dy < $signed({2'b0, geom.ph}));
		item.dx      = dx[28:0];
		item.dy      = dy[28:0];
	end

endmodule

`default_nettype wire

[src/cifs_fifo.sv]
// ---------------------------------------------------------------------------
// cifs_fifo: short queue between front and back
// Register-based first-in first-out buffer of QDEPTH entries.
// ---------------------------------------------------------------------------
`default_nettype none

module cifs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cifs_pkg::q_item_t   din,
	output logic                full,
	input  logic                pop,
	output cifs_pkg::q_item_t   dout,
	output logic                empty
);

	localparam int PW = $clog2(cifs_pkg::QDEPTH);

	cifs_pkg::q_item_t ent_q [cifs_pkg::QDEPTH];
	logic [PW-1:0]     wp_q, rp_q;
	logic [PW:0]       cnt_q;

	assign full  = (cnt_q == (PW+1)'(cifs_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= din;
	end

endmodule

`default_nettype wire

[src/cifs_back.sv]
// ---------------------------------------------------------------------------
// cifs_back: execution pipeline
// Scales offsets, divides by placed size, indexes the store, drives results.
// ---------------------------------------------------------------------------
`default_nettype none

module cifs_back #(
	parameter int IMAGE_PIXELS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  cifs_pkg::q_item_t   head,
	output logic                pop,
	input  cifs_pkg::geom_t     geom,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic                m_tuser
);

	localparam int AW = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1;
	localparam int QB = cifs_pkg::SRC_BITS;

	logic adv;

	// divider stages: index 0 is the multiply output
	logic              v_sd   [QB+1];
	logic              ld_sd  [QB+1];
	logic              cov_sd [QB+1];
	logic [11:0]       lidx_sd[QB+1];
	logic [31:0]       lrgb_sd[QB+1];
	logic [41:0]       rx_sd  [QB+1];
	logic [41:0]       ry_sd  [QB+1];
	logic [QB-1:0]     qx_sd  [QB+1];
	logic [QB-1:0]     qy_sd  [QB+1];

	logic [41:0]       shx [QB];
	logic [41:0]       shy [QB];
	logic              gex [QB];
	logic              gey [QB];

	logic              v_si, ld_si, cov_si;
	logic [11:0]       lidx_si;
	logic [31:0]       lrgb_si;
	logic [24:0]       idx_si;

	logic              v_sm, ld_sm, cov_sm, rng_sm;
	logic [31:0]       rd_sm;

	logic [31:0]       store_q [IMAGE_PIXELS];

	logic              out_v_q, out_cov_q;
	logic [31:0]       out_rgba_q;

	assign adv = !out_v_q || m_tready;
	assign pop = adv && !empty;

	always_comb begin
		for (int i = 0; i < QB; i++) begin
			shx[i] = 42'(geom.pw) << (QB - 1 - i);
			shy[i] = 42'(geom.ph) << (QB - 1 - i);
			gex[i] = rx_sd[i] >= shx[i];
			gey[i] = ry_sd[i] >= shy[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++) v_sd[i] <= 1'b0;
			v_si    <= 1'b0;
			v_sm    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_sd[0] <= !empty;
			for (int i = 0; i < QB; i++) v_sd[i+1] <= v_sd[i];
			v_si    <= v_sd[QB];
			v_sm    <= v_si;
			out_v_q <= v_sm && !ld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ld_sd[0]   <= head.ld;
			cov_sd[0]  <= head.cov;
			lidx_sd[0] <= head.ld_idx;
			lrgb_sd[0] <= head.ld_rgba;
			rx_sd[0]   <= 42'(head.dx * geom.iw);
			ry_sd[0]   <= 42'(head.dy * geom.ih);
			qx_sd[0]   <= '0;
			qy_sd[0]   <= '0;
			for (int i = 0; i < QB; i++) begin
				ld_sd[i+1]   <= ld_sd[i];
				cov_sd[i+1]  <= cov_sd[i];
				lidx_sd[i+1] <= lidx_sd[i];
				lrgb_sd[i+1] <= lrgb_sd[i];
				rx_sd[i+1]   <= gex[i] ? rx_sd[i] - shx[i] : rx_sd[i];
				ry_sd[i+1]   <= gey[i] ? ry_sd[i] - shy[i] : ry_sd[i];
				qx_sd[i+1]   <= {qx_sd[i][QB-2:0], gex[i]};
				qy_sd[i+1]   <= {qy_sd[i][QB-2:0], gey[i]};
			end
			ld_si   <= ld_sd[QB];
			cov_si  <= cov_sd[QB];
			lidx_si <= lidx_sd[QB];
			lrgb_si <= lrgb_sd[QB];
			idx_si  <= 25'(qy_sd[QB] * geom.iw) + 25'(qx_sd[QB]);
			ld_sm   <= ld_si;
			cov_sm  <= cov_si;
			rng_sm  <= 32'(idx_si) < 32'(IMAGE_PIXELS);
			rd_sm   <= store_q[AW'(idx_si)];
			out_rgba_q <= (cov_sm && rng_sm) ? rd_sm : geom.dcol;
			out_cov_q  <= cov_sm;
		end
	end

	// loads write at the same stage where renders read, so order holds
	always_ff @(posedge clk) begin
		if (adv && v_si && ld_si && (32'(lidx_si) < 32'(IMAGE_PIXELS)))
			store_q[AW'(lidx_si)] <= lrgb_si;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_rgba_q;
	assign m_tuser  = out_cov_q;

endmodule

`default_nettype wire

[src/cell_image_fragment_scaler_core.sv]
// Throughput: one beat per cycle unless geometry is busy or results stall; the
// per-pixel divider is a 12-stage pipeline. After reset and each register write
// the geometry unit runs size, compare and offset steps, with a 29-step serial
// divider in fit and fill modes between them; s_tready stays low meanwhile.
// Reset: asynchronous, active low; registers return to their reset values.
// The image store has no reset; an entry reads valid only once loaded.
// ---------------------------------------------------------------------------
// cell_image_fragment_scaler_core: places a stored RGBA image on a cell grid
// Load beats fill the source store; render beats return one target pixel.
// ---------------------------------------------------------------------------
`default_nettype none

module cell_image_fragment_scaler_core #(
	parameter int IMAGE_PIXELS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// pixel_index[11:0], pixel_rgba[43:12], cell_column[51:44],
	// cell_line[59:52], pixel_x[67:60], pixel_y[75:68], zero pad [79:76]
	input  logic [79:0] s_tdata,
	// func: 0 load, 1 render
	input  logic        s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// rgba[31:0]
	output logic [31:0] m_tdata,
	// covered
	output logic        m_tuser,
	// register write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cifs_pkg::geom_t   geom;
	logic              geom_ready;
	cifs_pkg::q_item_t q_in, q_out;
	logic              q_push, q_pop, q_full, q_empty;

	// registers and placement: size, fit/fill division, alignment offsets
	cifs_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.ready     (geom_ready)
	);

	// front: take beats, compute grid coordinate and coverage
	cifs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.geom       (geom),
		.geom_ready (geom_ready),
		.full       (q_full),
		.push       (q_push),
		.item       (q_in)
	);

	// queue: decouple front stalls from result back-pressure
	cifs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	// back: scale, divide, index store, hold result until taken
	cifs_back #(
		.IMAGE_PIXELS (IMAGE_PIXELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (q_out),
		.pop      (q_pop),
		.geom     (geom),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

[src/cifs_checker.sv]
// ---------------------------------------------------------------------------
// cifs_checker: port-level assertions
// Watches the top-level ports over time; bound to the core below.
// ---------------------------------------------------------------------------
`default_nettype none

module cifs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        cfg_we
);

	// a stalled result beat keeps its colour
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// a stalled result beat keeps its coverage flag
	a_hold_user: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tuser))
		else $error("coverage flag changed while stalled");

	// a register write starts a geometry recompute: input closes
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready ##1 !s_tready)
		else $error("input open during geometry recompute");

	// nothing comes out right after reset
	a_rst_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid && !s_tready)
		else $error("activity right after reset");

endmodule

bind cell_image_fragment_scaler_core cifs_checker u_chk (.*);

`default_nettype wire

[bench/cell_image_fragment_scaler_core_tb.sv]
// ---------------------------------------------------------------------------
// cell_image_fragment_scaler_core_tb: self-checking bench of the image scaler
// Loads source images, renders target pixels under many placements and
// compares every result beat with a local prediction of the scaler.
// ---------------------------------------------------------------------------
`default_nettype none

module cell_image_fragment_scaler_core_tb;

	localparam logic FN_LOAD   = 1'b0;
	localparam logic FN_RENDER = 1'b1;
	localparam int   STORE_N   = 4096;
	localparam int   SETTLE    = 80;

	typedef struct packed {
		logic        fn;
		logic [11:0] idx;
		logic [31:0] col;
		logic [7:0]  ccol;
		logic [7:0]  cline;
		logic [7:0]  px;
		logic [7:0]  py;
	} beat_t;

	typedef struct packed {
		logic [31:0] rgba;
		logic        cov;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	cell_image_fragment_scaler_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model copy of the scaler state
	logic [31:0] shadow_store [STORE_N];
	logic [12:0] m_iw, m_ih;
	logic [8:0]  m_cw, m_ch, m_sc, m_sl;
	logic [5:0]  m_mode;
	logic [31:0] m_dcol;

	pixel_t pending_pixels[$];
	int     fail_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     hold_off_cycles;
	int     renders_checked;
	int     beats_sent;

	always #10 clk = ~clk;

	// ---- prediction -------------------------------------------------------
	function automatic longint clampv(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// work out placement and the source pixel of one render beat
	function automatic pixel_t render_pixel(beat_t b);
		longint iw, ih, cw, ch, gw, gh, pw, ph, xo, yo, gx, gy, sx, sy, idx;
		int     rsz, al, ha, va;
		bit     wb;
		pixel_t r;
		iw = clampv(longint'(m_iw), 1, 4096);
		ih = clampv(longint'(m_ih), 1, 4096);
		cw = clampv(longint'(m_cw), 1, 256);
		ch = clampv(longint'(m_ch), 1, 256);
		gw = clampv(longint'(m_sc), 1, 256) * cw;
		gh = clampv(longint'(m_sl), 1, 256) * ch;
		rsz = int'(m_mode[1:0]);
		al = int'(m_mode[5:2]);
		pw = iw;
		ph = ih;
		if (rsz == int'(cifs_pkg::RSZ_FIT) || rsz == int'(cifs_pkg::RSZ_FILL)) begin
			wb = (rsz == int'(cifs_pkg::RSZ_FILL)) ? (gw * ih >= gh * iw)
			                                       : (gw * ih <= gh * iw);
			if (wb) begin
				pw = gw;
				ph = (ih * gw) / iw;
			end else begin
				pw = (iw * gh) / ih;
				ph = gh;
			end
		end else if (rsz == int'(cifs_pkg::RSZ_STRETCH)) begin
			pw = gw;
			ph = gh;
		end
		if (al > 8) al = 0;
		ha = al % 3;
		va = al / 3;
		// SV division of signed longint truncates toward zero, as wanted
		xo = (ha == int'(cifs_pkg::AL_START)) ? 0 :
		     (ha == int'(cifs_pkg::AL_CENTER)) ? (gw - pw) / 2 : (gw - pw);
		yo = (va == int'(cifs_pkg::AL_START)) ? 0 :
		     (va == int'(cifs_pkg::AL_CENTER)) ? (gh - ph) / 2 : (gh - ph);
		gx = longint'(b.ccol) * cw + longint'(b.px);
		gy = longint'(b.cline) * ch + longint'(b.py);
		r.rgba = m_dcol;
		r.cov = 1'b0;
		if (pw > 0 && ph > 0 && gx >= xo && gx < xo + pw && gy >= yo && gy < yo + ph) begin
			sx = ((gx - xo) * iw) / pw;
			sy = ((gy - yo) * ih) / ph;
			idx = sy * iw + sx;
			r.cov = 1'b1;
			if (idx < STORE_N) r.rgba = shadow_store[idx];
		end
		return r;
	endfunction

	// ---- drivers ------------------------------------------------------------
	task automatic write_reg(logic [2:0] index, logic [31:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (index)
			cifs_pkg::REG_IMAGE_WIDTH:    m_iw = value[12:0];
			cifs_pkg::REG_IMAGE_HEIGHT:   m_ih = value[12:0];
			cifs_pkg::REG_CELL_WIDTH:     m_cw = value[8:0];
			cifs_pkg::REG_CELL_HEIGHT:    m_ch = value[8:0];
			cifs_pkg::REG_SPAN_COLUMNS:   m_sc = value[8:0];
			cifs_pkg::REG_SPAN_LINES:     m_sl = value[8:0];
			cifs_pkg::REG_PLACEMENT_MODE: m_mode = value[5:0];
			cifs_pkg::REG_DEFAULT_COLOR:  m_dcol = value;
			default: ;
		endcase
	endtask

	task automatic drain_results();
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// offer one beat; update the model on acceptance
	task automatic send_beat(beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = b.fn;
		s_tdata = {4'd0, b.py, b.px, b.cline, b.ccol, b.col, b.idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (b.fn == FN_LOAD) begin
			shadow_store[b.idx] = b.col;
		end else begin
			pending_pixels.push_back(render_pixel(b));
		end
		beats_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// load the whole current image with random colours
	task automatic load_image();
		beat_t b;
		longint n;
		n = clampv(longint'(m_iw), 1, 4096) * clampv(longint'(m_ih), 1, 4096);
		if (n > STORE_N) n = STORE_N;
		for (int i = 0; i < n; i++) begin
			b = '0;
			b.fn = FN_LOAD;
			b.idx = 12'(i);
			b.col = $urandom;
			b.ccol = 8'($urandom);
			b.cline = 8'($urandom);
			b.px = 8'($urandom);
			b.py = 8'($urandom);
			send_beat(b);
		end
	endtask

	// random render beat that stays mostly near the grid
	function automatic beat_t random_render();
		beat_t b;
		int gcw, gch;
		b = '0;
		b.fn = FN_RENDER;
		b.idx = 12'($urandom);
		b.col = $urandom;
		gcw = int'(clampv(longint'(m_sc), 1, 256));
		gch = int'(clampv(longint'(m_sl), 1, 256));
		if ($urandom_range(9) == 0) begin
			b.ccol = 8'($urandom);
			b.cline = 8'($urandom);
			b.px = 8'($urandom);
			b.py = 8'($urandom);
		end else begin
			b.ccol = 8'($urandom_range(gcw - 1 > 255 ? 255 : gcw - 1));
			b.cline = 8'($urandom_range(gch - 1 > 255 ? 255 : gch - 1));
			b.px = 8'($urandom_range(int'(clampv(longint'(m_cw), 1, 256)) - 1));
			b.py = 8'($urandom_range(int'(clampv(longint'(m_ch), 1, 256)) - 1));
		end
		return b;
	endfunction

	// ---- receiver and checker ----------------------------------------------
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			m_tready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result beat rgba=%h covered=%b", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				renders_checked++;
				if (m_tdata !== want.rgba) begin
					$error("rgba: expected %h, actual %h", want.rgba, m_tdata);
					fail_count++;
				end
				if (m_tuser !== want.cov) begin
					$error("covered: expected %b, actual %b", want.cov, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// ---- directed table -----------------------------------------------------
	typedef struct {
		logic [12:0] iw, ih;
		logic [8:0]  cw, ch, sc, sl;
		logic [5:0]  mode;
		logic [31:0] dcol;
		logic [7:0]  ccol, cline, px, py;
		bit          known;
		pixel_t      want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	function automatic dir_row_t mk(int iw, int ih, int cw, int ch, int sc, int sl,
			int mode, logic [31:0] dcol, int cc, int cl, int px, int py,
			bit known, logic [31:0] rgba, bit cov);
		dir_row_t r;
		r.iw = 13'(iw); r.ih = 13'(ih); r.cw = 9'(cw); r.ch = 9'(ch);
		r.sc = 9'(sc); r.sl = 9'(sl);
		r.mode = 6'(mode); r.dcol = dcol;
		r.ccol = 8'(cc); r.cline = 8'(cl); r.px = 8'(px); r.py = 8'(py);
		r.known = known;
		r.want.rgba = rgba;
		r.want.cov = cov;
		return r;
	endfunction

	task automatic apply_geometry(logic [12:0] iw, logic [12:0] ih, logic [8:0] cw,
			logic [8:0] ch, logic [8:0] sc, logic [8:0] sl, logic [5:0] mode,
			logic [31:0] dcol);
		drain_results();
		write_reg(cifs_pkg::REG_IMAGE_WIDTH, 32'(iw));
		write_reg(cifs_pkg::REG_IMAGE_HEIGHT, 32'(ih));
		write_reg(cifs_pkg::REG_CELL_WIDTH, 32'(cw));
		write_reg(cifs_pkg::REG_CELL_HEIGHT, 32'(ch));
		write_reg(cifs_pkg::REG_SPAN_COLUMNS, 32'(sc));
		write_reg(cifs_pkg::REG_SPAN_LINES, 32'(sl));
		write_reg(cifs_pkg::REG_PLACEMENT_MODE, 32'(mode));
		write_reg(cifs_pkg::REG_DEFAULT_COLOR, dcol);
	endtask

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		beat_t    b;
		pixel_t   p;
		dir_row_t r;
		int       phase;
		int       npix;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		renders_checked = 0;
		beats_sent = 0;
		m_iw = 13'd1; m_ih = 13'd1; m_cw = 9'd8; m_ch = 9'd16; m_sc = 9'd1; m_sl = 9'd1;
		m_mode = 6'd0; m_dcol = 32'd0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// after reset: 1x1 image in an 8x16 cell, only the corner is covered;
		// load the single pixel first so the store read is defined
		b = '0;
		b.fn = FN_LOAD;
		b.col = 32'hA1B2C3D4;
		send_beat(b);
		b.fn = FN_RENDER;
		send_beat(b);
		b.px = 8'd1;
		send_beat(b);
		b.px = 8'd255; b.py = 8'd255; b.ccol = 8'd255; b.cline = 8'd255;
		send_beat(b);
		drain_results();

		// stretch the 1x1 image over the grid: everything inside covered
		dir_rows.push_back(mk(1, 1, 8, 16, 1, 1, int'(cifs_pkg::RSZ_STRETCH), 32'hFFFFFFFF,
			0, 0, 7, 15, 1, 32'hA1B2C3D4, 1));
		dir_rows.push_back(mk(1, 1, 8, 16, 1, 1, int'(cifs_pkg::RSZ_STRETCH), 32'hFFFFFFFF,
			1, 0, 0, 0, 1, 32'hFFFFFFFF, 0));
		// zero registers clamp to one; bottom-end alignment of 1x1 in 1x1
		dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 8 * 4, 32'h12345678,
			0, 0, 0, 0, 1, 32'hA1B2C3D4, 1));
		// alignment codes 9..15 act as top-start
		dir_rows.push_back(mk(1, 1, 4, 4, 2, 2, 15 * 4, 32'h0,
			0, 0, 0, 0, 1, 32'hA1B2C3D4, 1));
		dir_rows.push_back(mk(1, 1, 4, 4, 2, 2, 9 * 4 + int'(cifs_pkg::RSZ_NONE), 32'h0,
			1, 1, 3, 3, 1, 32'h0, 0));
		// the rest go through the predictor: every resize, alignments 0..3 and 5..8
		for (int m = 0; m < 36; m += 5)
			dir_rows.push_back(mk(1, 1, 3, 5, 3, 2, m, 32'h55AA55AA,
				int'($urandom_range(3)), int'($urandom_range(2)),
				int'($urandom_range(4)), int'($urandom_range(6)), 0, 0, 0));
		// largest registers, last pixel of the last cell
		dir_rows.push_back(mk(8191, 8191, 511, 511, 511, 511, int'(cifs_pkg::RSZ_NONE),
			32'h0, 255, 255, 255, 255, 0, 0, 0));
		dir_rows.push_back(mk(1, 1, 256, 256, 256, 256, int'(cifs_pkg::RSZ_FIT) + 4 * 4,
			32'h0, 128, 128, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(1, 1, 256, 256, 256, 256, int'(cifs_pkg::RSZ_FILL) + 8 * 4,
			32'h0, 255, 255, 255, 255, 0, 0, 0));

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			apply_geometry(r.iw, r.ih, r.cw, r.ch, r.sc, r.sl, r.mode, r.dcol);
			b = '0;
			b.fn = FN_RENDER;
			b.ccol = r.ccol; b.cline = r.cline; b.px = r.px; b.py = r.py;
			if (r.known) begin
				p = render_pixel(b);
				if (p !== r.want) begin
					$error("table row %0d: rgba/covered expected %h/%b, model %h/%b",
						i, r.want.rgba, r.want.cov, p.rgba, p.cov);
					fail_count++;
				end
			end
			send_beat(b);
		end
		// a load beyond image bounds but within the store, extreme index
		b = '0;
		b.fn = FN_LOAD;
		b.idx = 12'hFFF;
		b.col = 32'hFFFFFFFF;
		send_beat(b);
		drain_results();

		// random phases: new geometry, full image load, then renders
		for (phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			if (phase == 0)
				apply_geometry(13'd1, 13'd1, 9'd1, 9'd1, 9'd1, 9'd1,
					6'(cifs_pkg::RSZ_NONE), $urandom);
			else if (phase == 1)
				apply_geometry(13'd8, 13'd8, 9'd256, 9'd256, 9'd256, 9'd256,
					6'(cifs_pkg::RSZ_FILL) + 6'd16, $urandom);
			else
				apply_geometry(
					13'($urandom_range(1, 12) * (($urandom_range(9) == 0) ? 5 : 1)),
					13'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
					9'($urandom_range(1, 12)), 9'($urandom_range(1, 8)),
					9'($urandom_range(1, 8)), 6'($urandom_range(0, 63)),
					$urandom);
			// every covered pixel reads inside the loaded image, so loads first
			load_image();
			if (phase == 5) hold_off_cycles = 200;
			npix = int'(clampv(longint'(m_iw), 1, 4096) * clampv(longint'(m_ih), 1, 4096));
			if (npix > STORE_N) npix = STORE_N;
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(19) == 0) begin
					// reload a random image pixel with new content
					b = '0;
					b.fn = FN_LOAD;
					b.idx = 12'($urandom_range(npix - 1));
					b.col = $urandom;
					send_beat(b);
				end else begin
					send_beat(random_render());
				end
				// pause until every expected result is in
				if (phase == 7 && k == 30) drain_results();
			end
		end

		send_idle_pct = 0;
		drain_results();
		$display("Run covered %0d accepted input beats and %0d checked render results",
			beats_sent, renders_checked);
		$display("over all resize modes, alignments, register extremes and idle patterns.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
